// File: src/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// shared types and constants of the pulse pair coincidence block
// ----------------------------------------------------------------------------
package ppc_pkg;

    // capacity of the stored pulse-time file
    localparam int MAX_PULSES = 16;
    localparam int IDX_W      = $clog2(MAX_PULSES);
    localparam int CNT_W      = $clog2(MAX_PULSES + 1);

    // work queue between front and back
    localparam int WQ_DEPTH = 4;
    localparam int WQ_PTR_W = $clog2(WQ_DEPTH);
    localparam int WQ_CNT_W = $clog2(WQ_DEPTH + 1);

    // result queue at the output
    localparam int RQ_DEPTH = 2;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    localparam int DATA_W = 16;
    localparam int APB_W  = 32;
    localparam int ADDR_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_TIME_WINDOW   = 1'b0;
    localparam logic REG_AMP_THRESHOLD = 1'b1;

    localparam logic [DATA_W-1:0] TIME_WINDOW_RST   = 16'd80;
    localparam logic [DATA_W-1:0] AMP_THRESHOLD_RST = 16'd1600;

    // one classified pulse
    typedef struct packed {
        logic [DATA_W-1:0] peak_time;
        logic              qual;
        logic              last;
    } item_t;

    // one event result
    typedef struct packed {
        logic found;
        logic overflowed;
    } result_t;

    // work queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } wq_stat_t;

endpackage

// File: src/pulse_pair_coincidence_top.sv
// ----------------------------------------------------------------------------
// pulse_pair_coincidence_top
// time-window coincidence detector over the qualifying pulses of an event
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// -------   ---------  -------------------  ---------------------------------
// pulse     in         push / full          peak_time, pulse_amplitude,
//                                           last_pulse
// result    out        pop / empty          coincidence_found,
//                                           buffer_overflowed
// config    in         psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// one pulse per cycle sustained while the result queue has room; each pulse is
// compared with all stored times at once; a last pulse passes the input
// register, work queue and compare bank, then its result enters the result queue
// reset clears all control state; the stored-time file needs no clearing pass
// a held-off pop fills the two-entry result queue, then the four-entry work
// queue, then the input register, and only then does full rise
//
module pulse_pair_coincidence_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    // pulse channel
    input  logic                               push,
    output logic                               full,
    input  logic [ppc_pkg::DATA_W-1:0]         peak_time,
    input  logic signed [ppc_pkg::DATA_W-1:0]  pulse_amplitude,
    input  logic                               last_pulse,
    // result channel
    output logic                               empty,
    input  logic                               pop,
    output logic                               coincidence_found,
    output logic                               buffer_overflowed,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppc_pkg::ADDR_W-1:0]         paddr,
    input  logic [ppc_pkg::APB_W-1:0]          pwdata,
    output logic [ppc_pkg::APB_W-1:0]          prdata,
    output logic                               pready
);

    // configuration registers
    logic [ppc_pkg::DATA_W-1:0]        time_window_reg;
    logic signed [ppc_pkg::DATA_W-1:0] amp_threshold_reg;
    logic                              cfg_wr;

    // front to work queue
    logic              wq_push;
    ppc_pkg::item_t    wq_in_item;
    ppc_pkg::wq_stat_t wq_stat;

    // work queue to back
    logic              wq_pop;
    ppc_pkg::item_t    wq_out_item;

    // ------------------------------------------------------------------
    // configuration port: zero wait states, register picked by paddr[2]
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_window_reg   <= ppc_pkg::TIME_WINDOW_RST;
            amp_threshold_reg <= ppc_pkg::AMP_THRESHOLD_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                ppc_pkg::REG_TIME_WINDOW:
                begin
                    time_window_reg <= pwdata[ppc_pkg::DATA_W-1:0];
                end
                ppc_pkg::REG_AMP_THRESHOLD:
                begin
                    amp_threshold_reg <= pwdata[ppc_pkg::DATA_W-1:0];
                end
                default:
                begin
                    time_window_reg <= time_window_reg;
                end
            endcase
        end
    end

    // read back; threshold returns sign extended
    always_comb
    begin
        unique case (paddr[2])
            ppc_pkg::REG_TIME_WINDOW:
            begin
                prdata = {{(ppc_pkg::APB_W-ppc_pkg::DATA_W){1'b0}}, time_window_reg};
            end
            ppc_pkg::REG_AMP_THRESHOLD:
            begin
                prdata = {{(ppc_pkg::APB_W-ppc_pkg::DATA_W){amp_threshold_reg[ppc_pkg::DATA_W-1]}},
                          amp_threshold_reg};
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // front: accept beat, classify against threshold
    // ------------------------------------------------------------------
    ppc_front u_front
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .push                (push),
        .full                (full),
        .peak_time           (peak_time),
        .pulse_amplitude     (pulse_amplitude),
        .last_pulse          (last_pulse),
        .amplitude_threshold (amp_threshold_reg),
        .wq_stat             (wq_stat),
        .wq_push             (wq_push),
        .wq_item             (wq_in_item)
    );

    // ------------------------------------------------------------------
    // work queue: lets front and back stall apart
    // ------------------------------------------------------------------
    ppc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (wq_push),
        .push_item (wq_in_item),
        .pop       (wq_pop),
        .pop_item  (wq_out_item),
        .stat      (wq_stat)
    );

    // ------------------------------------------------------------------
    // back: compare bank, event flags, result queue
    // ------------------------------------------------------------------
    ppc_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .wq_empty          (wq_stat.empty),
        .wq_item           (wq_out_item),
        .wq_pop            (wq_pop),
        .time_window       (time_window_reg),
        .empty             (empty),
        .pop               (pop),
        .coincidence_found (coincidence_found),
        .buffer_overflowed (buffer_overflowed)
    );

endmodule

// File: src/ppc_front.sv
// ----------------------------------------------------------------------------
// ppc_front
// input register: accepts pulses and marks the ones at or above threshold
// ----------------------------------------------------------------------------
module ppc_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [ppc_pkg::DATA_W-1:0]        peak_time,
    input  logic signed [ppc_pkg::DATA_W-1:0] pulse_amplitude,
    input  logic                              last_pulse,
    input  logic signed [ppc_pkg::DATA_W-1:0] amplitude_threshold,
    input  ppc_pkg::wq_stat_t                 wq_stat,
    output logic                              wq_push,
    output ppc_pkg::item_t                    wq_item
);

    logic           valid_reg;
    logic           valid_next;
    ppc_pkg::item_t item_reg;
    logic           accept;

    assign full    = valid_reg && wq_stat.full;
    assign accept  = push && !full;
    assign wq_push = valid_reg && !wq_stat.full;
    assign wq_item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (wq_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, classified on the way in
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.peak_time <= peak_time;
            item_reg.qual      <= (pulse_amplitude >= amplitude_threshold);
            item_reg.last      <= last_pulse;
        end
    end

endmodule

// File: src/ppc_queue.sv
// ----------------------------------------------------------------------------
// ppc_queue
// short work queue of classified pulses between front and back
// ----------------------------------------------------------------------------
module ppc_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ppc_pkg::item_t    push_item,
    input  logic              pop,
    output ppc_pkg::item_t    pop_item,
    output ppc_pkg::wq_stat_t stat
);

    ppc_pkg::item_t                 mem [ppc_pkg::WQ_DEPTH];
    logic [ppc_pkg::WQ_PTR_W-1:0]   wr_ptr_reg;
    logic [ppc_pkg::WQ_PTR_W-1:0]   wr_ptr_next;
    logic [ppc_pkg::WQ_PTR_W-1:0]   rd_ptr_reg;
    logic [ppc_pkg::WQ_PTR_W-1:0]   rd_ptr_next;
    logic [ppc_pkg::WQ_CNT_W-1:0]   cnt_reg;
    logic [ppc_pkg::WQ_CNT_W-1:0]   cnt_next;
    logic                           do_push;
    logic                           do_pop;

    assign stat.full  = (cnt_reg == ppc_pkg::WQ_CNT_W'(ppc_pkg::WQ_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == ppc_pkg::WQ_PTR_W'(ppc_pkg::WQ_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ppc_pkg::WQ_PTR_W'(ppc_pkg::WQ_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    // occupancy stays within the storage
    a_wq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ppc_pkg::WQ_CNT_W'(ppc_pkg::WQ_DEPTH))
        else $error("work queue occupancy beyond depth");
`endif

endmodule

// File: src/ppc_back.sv
// ----------------------------------------------------------------------------
// ppc_back
// compare bank against stored pulse times, event flags and result queue
// ----------------------------------------------------------------------------
module ppc_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wq_empty,
    input  ppc_pkg::item_t             wq_item,
    output logic                       wq_pop,
    input  logic [ppc_pkg::DATA_W-1:0] time_window,
    output logic                       empty,
    input  logic                       pop,
    output logic                       coincidence_found,
    output logic                       buffer_overflowed
);

    logic [ppc_pkg::DATA_W-1:0]   times_reg [ppc_pkg::MAX_PULSES];
    logic [ppc_pkg::CNT_W-1:0]    cnt_reg;
    logic [ppc_pkg::CNT_W-1:0]    cnt_next;
    logic                         found_reg;
    logic                         found_next;
    logic                         ovf_reg;
    logic                         ovf_next;
    logic [ppc_pkg::MAX_PULSES-1:0] hit;
    logic                         room;
    logic                         store;

    ppc_pkg::result_t             rq [ppc_pkg::RQ_DEPTH];
    logic [ppc_pkg::RQ_PTR_W-1:0] rq_wr_reg;
    logic [ppc_pkg::RQ_PTR_W-1:0] rq_rd_reg;
    logic [ppc_pkg::RQ_CNT_W-1:0] rq_cnt_reg;
    logic [ppc_pkg::RQ_CNT_W-1:0] rq_cnt_next;
    logic                         rq_full;
    logic                         rq_push;
    logic                         rq_pop;
    ppc_pkg::result_t             res;

    assign rq_full = (rq_cnt_reg == ppc_pkg::RQ_CNT_W'(ppc_pkg::RQ_DEPTH));
    assign empty   = (rq_cnt_reg == '0);
    assign rq_pop  = pop && !empty;
    assign coincidence_found = rq[rq_rd_reg].found;
    assign buffer_overflowed = rq[rq_rd_reg].overflowed;

    // a last pulse needs a free result slot
    assign wq_pop  = !wq_empty && (!wq_item.last || !rq_full);
    assign rq_push = wq_pop && wq_item.last;

    // one comparator per stored entry
    always_comb
    begin
        logic [ppc_pkg::DATA_W-1:0] diff;
        for (int i = 0; i < ppc_pkg::MAX_PULSES; i++)
        begin
            diff = (wq_item.peak_time >= times_reg[i])
                 ? wq_item.peak_time - times_reg[i]
                 : times_reg[i] - wq_item.peak_time;
            hit[i] = (ppc_pkg::CNT_W'(i) < cnt_reg) && (diff < time_window);
        end
    end

    assign room  = (cnt_reg < ppc_pkg::CNT_W'(ppc_pkg::MAX_PULSES));
    assign store = wq_pop && wq_item.qual && room;

    always_comb
    begin
        cnt_next   = cnt_reg;
        found_next = found_reg;
        ovf_next   = ovf_reg;
        if (wq_pop && wq_item.qual)
        begin
            found_next = found_reg || (|hit);
            if (room)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        res.found      = found_next;
        res.overflowed = ovf_next;
        // event ends: clear for the next one
        if (rq_push)
        begin
            cnt_next   = '0;
            found_next = 1'b0;
            ovf_next   = 1'b0;
        end
    end

    always_comb
    begin
        rq_cnt_next = rq_cnt_reg;
        if (rq_push && !rq_pop)
        begin
            rq_cnt_next = rq_cnt_reg + 1'b1;
        end
        else if (rq_pop && !rq_push)
        begin
            rq_cnt_next = rq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            found_reg  <= 1'b0;
            ovf_reg    <= 1'b0;
            rq_wr_reg  <= '0;
            rq_rd_reg  <= '0;
            rq_cnt_reg <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            found_reg  <= found_next;
            ovf_reg    <= ovf_next;
            rq_cnt_reg <= rq_cnt_next;
            if (rq_push)
            begin
                rq_wr_reg <= (rq_wr_reg == ppc_pkg::RQ_PTR_W'(ppc_pkg::RQ_DEPTH - 1))
                           ? '0 : rq_wr_reg + 1'b1;
            end
            if (rq_pop)
            begin
                rq_rd_reg <= (rq_rd_reg == ppc_pkg::RQ_PTR_W'(ppc_pkg::RQ_DEPTH - 1))
                           ? '0 : rq_rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            times_reg[cnt_reg[ppc_pkg::IDX_W-1:0]] <= wq_item.peak_time;
        end
        if (rq_push)
        begin
            rq[rq_wr_reg] <= res;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ppc_pkg::CNT_W'(ppc_pkg::MAX_PULSES))
        else $error("stored pulse count beyond capacity");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (cnt_reg == ppc_pkg::CNT_W'(ppc_pkg::MAX_PULSES)))
        else $error("overflow flagged with free entries");

    a_event_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rq_push |=> (cnt_reg == '0) && !found_reg && !ovf_reg)
        else $error("event state not cleared after last pulse");
`endif

endmodule
